// ----- hw/rtl/slw_pkg.sv -----
package slw_pkg;

  // Shadow RAM size in nibbles (2..64)
  localparam int RAM_WORDS = 32;
  localparam int RAM_AW    = $clog2(RAM_WORDS);

  localparam int OP_W     = 3;
  localparam int ADDR_W   = 6;
  localparam int NIBBLE_W = 4;
  localparam int BIDX_W   = 2;
  localparam int CODE_W   = 8;
  localparam int FRAME_W  = 13;
  localparam int LEN_W    = 4;

  localparam logic [ADDR_W:0]   RAM_LIMIT       = (ADDR_W+1)'(RAM_WORDS);
  localparam logic [ADDR_W-1:0] LAST_ADDR       = ADDR_W'(RAM_WORDS - 1);
  localparam logic [NIBBLE_W-1:0] NIBBLE_ALL    = '1;
  localparam logic [LEN_W-1:0]  FRAME_LEN_WRITE = LEN_W'(13);
  localparam logic [LEN_W-1:0]  FRAME_LEN_CMD   = LEN_W'(12);
  localparam logic [2:0]        WRITE_HDR       = 3'b101;
  localparam logic [2:0]        CMD_HDR         = 3'b100;

  // Queue between front and back, power of two depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_MASK  = 3'd0,
    OP_BIT   = 3'd1,
    OP_RAW   = 3'd2,
    OP_CMD   = 3'd3,
    OP_CLEAR = 3'd4,
    OP_FILL  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    K_UPD,
    K_RAW,
    K_CMD,
    K_SWEEP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [ADDR_W-1:0]   address;
    logic [NIBBLE_W-1:0] sel;
    logic                turn_on;
    logic [NIBBLE_W-1:0] nibble;
    logic [CODE_W-1:0]   command_code;
  } cmd_t;

  function automatic logic [NIBBLE_W-1:0] reverse_nibble(input logic [NIBBLE_W-1:0] v);
    logic [NIBBLE_W-1:0] r;
    for (int i = 0; i < NIBBLE_W; i++) begin
      r[i] = v[NIBBLE_W-1-i];
    end
    return r;
  endfunction

  // 101, address MSB first, data LSB first
  function automatic logic [FRAME_W-1:0] write_frame(input logic [ADDR_W-1:0] addr,
                                                     input logic [NIBBLE_W-1:0] data);
    return {WRITE_HDR, addr, reverse_nibble(data)};
  endfunction

  // 100, code MSB first, trailing zero; bit 12 unused
  function automatic logic [FRAME_W-1:0] cmd_frame(input logic [CODE_W-1:0] code);
    return {1'b0, CMD_HDR, code, 1'b0};
  endfunction

endpackage

// ----- hw/rtl/slw_in_if.sv -----
interface slw_in_if import slw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ADDR_W-1:0]   address;
  logic [NIBBLE_W-1:0] bit_mask;
  logic [BIDX_W-1:0]   bit_index;
  logic                turn_on;
  logic [NIBBLE_W-1:0] raw_nibble;
  logic [CODE_W-1:0]   command_code;

  modport source (
    output valid, op, address, bit_mask, bit_index, turn_on, raw_nibble, command_code,
    input  ready
  );
  modport sink (
    input  valid, op, address, bit_mask, bit_index, turn_on, raw_nibble, command_code,
    output ready
  );
endinterface

// ----- hw/rtl/slw_out_if.sv -----
interface slw_out_if import slw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_bits;
  logic [LEN_W-1:0]   frame_length;
  logic               last;

  modport source (
    output valid, frame_bits, frame_length, last,
    input  ready
  );
  modport sink (
    input  valid, frame_bits, frame_length, last,
    output ready
  );
endinterface

// ----- hw/rtl/slw_ram.sv -----
module slw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/slw_front.sv -----
module slw_front import slw_pkg::*; (
  slw_in_if.sink in_i,
  input  logic   full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  logic keep;
  logic in_range;

  assign in_range = {1'b0, in_i.address} < RAM_LIMIT;

  always_comb begin
    keep               = 1'b0;
    cmd_o.kind         = K_RAW;
    cmd_o.address      = in_i.address;
    cmd_o.sel          = in_i.bit_mask;
    cmd_o.turn_on      = in_i.turn_on;
    cmd_o.nibble       = in_i.raw_nibble;
    cmd_o.command_code = in_i.command_code;
    case (in_i.op)
      OP_MASK: begin
        cmd_o.kind = K_UPD;
        keep       = in_range;
      end
      OP_BIT: begin
        cmd_o.kind = K_UPD;
        cmd_o.sel  = NIBBLE_W'(1) << in_i.bit_index;
        keep       = in_range;
      end
      OP_RAW: begin
        cmd_o.kind = K_RAW;
        keep       = 1'b1;
      end
      OP_CMD: begin
        cmd_o.kind = K_CMD;
        keep       = 1'b1;
      end
      OP_CLEAR: begin
        cmd_o.kind   = K_SWEEP;
        cmd_o.nibble = '0;
        keep         = 1'b1;
      end
      OP_FILL: begin
        cmd_o.kind   = K_SWEEP;
        cmd_o.nibble = NIBBLE_ALL;
        keep         = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // dropped items (out-of-range updates, unused ops) are taken and discarded
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && keep;

endmodule

// ----- hw/rtl/slw_fifo.sv -----
module slw_fifo import slw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, wptr_d;
  logic [QUEUE_AW-1:0] rptr_q, rptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q + (QUEUE_AW+1)'(push_i) - (QUEUE_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/slw_back.sv -----
module slw_back import slw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic pop_o,
  slw_out_if.source out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SWEEP
  } state_e;

  state_e              state_q, state_d;
  cmd_t                ent_q, ent_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic                ovalid_q, ovalid_d;
  logic [FRAME_W-1:0]  obits_q, obits_d;
  logic [LEN_W-1:0]    olen_q, olen_d;
  logic                olast_q, olast_d;
  logic [RAM_WORDS-1:0] vld_q, vld_d;

  logic                out_free;
  logic                ram_we, ram_re;
  logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [NIBBLE_W-1:0] ram_wdata, ram_rdata;
  logic [NIBBLE_W-1:0] cur, upd;
  logic                sweep_last;

  slw_ram #(
    .WIDTH(NIBBLE_W),
    .DEPTH(RAM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !ovalid_q || out_o.ready;
  // entries never written since reset read as zero
  assign cur        = vld_q[ent_q.address[RAM_AW-1:0]] ? ram_rdata : '0;
  assign upd        = ent_q.turn_on ? (cur | ent_q.sel) : (cur & ~ent_q.sel);
  assign sweep_last = cnt_q == LAST_ADDR;
  assign ram_raddr  = q_cmd_i.address[RAM_AW-1:0];

  always_comb begin
    state_d   = state_q;
    ent_d     = ent_q;
    cnt_d     = cnt_q;
    vld_d     = vld_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    obits_d   = obits_q;
    olen_d    = olen_q;
    olast_d   = olast_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ent_q.address[RAM_AW-1:0];
    ram_wdata = upd;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          ent_d = q_cmd_i;
          case (q_cmd_i.kind)
            K_RAW: begin
              ovalid_d = 1'b1;
              obits_d  = write_frame(q_cmd_i.address, q_cmd_i.nibble);
              olen_d   = FRAME_LEN_WRITE;
              olast_d  = 1'b1;
            end
            K_CMD: begin
              ovalid_d = 1'b1;
              obits_d  = cmd_frame(q_cmd_i.command_code);
              olen_d   = FRAME_LEN_CMD;
              olast_d  = 1'b1;
            end
            K_UPD: begin
              ram_re  = 1'b1;
              state_d = S_READ;
            end
            K_SWEEP: begin
              cnt_d   = '0;
              state_d = S_SWEEP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          ram_we                              = 1'b1;
          vld_d[ent_q.address[RAM_AW-1:0]]    = 1'b1;
          ovalid_d                            = 1'b1;
          obits_d                             = write_frame(ent_q.address, upd);
          olen_d                              = FRAME_LEN_WRITE;
          olast_d                             = 1'b1;
          state_d                             = S_IDLE;
        end
      end
      S_SWEEP: begin
        ram_waddr = cnt_q[RAM_AW-1:0];
        ram_wdata = ent_q.nibble;
        if (out_free) begin
          ram_we                    = 1'b1;
          vld_d[cnt_q[RAM_AW-1:0]]  = 1'b1;
          ovalid_d                  = 1'b1;
          obits_d                   = write_frame(cnt_q, ent_q.nibble);
          olen_d                    = FRAME_LEN_WRITE;
          olast_d                   = sweep_last;
          cnt_d                     = cnt_q + 1'b1;
          if (sweep_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      vld_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      vld_q    <= vld_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    obits_q <= obits_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.frame_bits   = obits_q;
  assign out_o.frame_length = olen_q;
  assign out_o.last         = olast_q;

endmodule

// ----- hw/rtl/segment_lcd_shadow_writer.sv -----
// Segment-LCD shadow writer.
// in_i takes one request per transfer (mask/bit update, raw write, command,
// clear all, fill all); out_o gives one serial frame per transfer, with last
// set on the final frame of a request. Frames are MSB-first in frame_bits.
// A front decoder drops out-of-range updates and unused ops and pushes the
// rest into a two-entry queue; in_i.ready is low only while that queue is full.
// The back end works one request at a time against a RAM_WORDS-nibble shadow
// RAM (single write port, registered read port).
// Into an idle block, a raw write or command passes through the queue and the
// frame register before it can transfer out; an update also waits for the
// registered shadow RAM read.
// In the back end, a raw write or command is taken in the idle state and an
// update adds a read state; clear/fill take one start step and then one frame
// and one RAM write per cycle while out_o is free, set by the single RAM write port.
// Reset clears per-entry valid flags at once, so the shadow reads as all zero
// with no clearing pass; the block can accept right after reset.
// When out_o.ready is low with a frame held, the frame register holds and the back
// end stalls; the queue keeps accepting until it is full.
module segment_lcd_shadow_writer import slw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  slw_in_if.sink    in_i,
  slw_out_if.source out_o
);

  logic push, full, pop, q_valid;
  cmd_t push_cmd, head_cmd;

  slw_front u_front (
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .cmd_o (push_cmd)
  );

  slw_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  slw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_cmd_i  (head_cmd),
    .pop_o    (pop),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_write_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_length == FRAME_LEN_WRITE |->
      out_o.frame_bits[FRAME_W-1 -: 3] == WRITE_HDR)
    else $error("write frame header wrong");

  a_cmd_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_length == FRAME_LEN_CMD |->
      !out_o.frame_bits[FRAME_W-1] && !out_o.frame_bits[0] && out_o.last)
    else $error("command frame malformed");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue pushed while full");
`endif

endmodule

// ----- tb/slw_frame_checker.sv -----
`timescale 1ns / 100ps

module slw_frame_checker import slw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  slw_in_if    req_mon,
  slw_out_if   frame_mon,
  output int   mismatches_o,
  output int   frames_pending_o
);

  typedef struct packed {
    logic [FRAME_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic               last;
  } lcd_frame_t;

  lcd_frame_t          frames_due [$];
  logic [NIBBLE_W-1:0] shadow_nib [RAM_WORDS];

  function automatic lcd_frame_t nibble_write_frame(input logic [ADDR_W-1:0] addr,
                                                    input logic [NIBBLE_W-1:0] data,
                                                    input logic fin);
    lcd_frame_t f;
    // data goes out LSB first, so it lands bit-reversed in the frame
    f.bits = {WRITE_HDR, addr, data[0], data[1], data[2], data[3]};
    f.len  = FRAME_LEN_WRITE;
    f.last = fin;
    return f;
  endfunction

  task automatic apply_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [NIBBLE_W-1:0] mask,
                               input logic [BIDX_W-1:0] idx, input logic on,
                               input logic [NIBBLE_W-1:0] raw,
                               input logic [CODE_W-1:0] code);
    logic [NIBBLE_W-1:0] sel;
    logic [NIBBLE_W-1:0] nib;
    lcd_frame_t          f;
    case (op)
      OP_MASK, OP_BIT: begin
        if (int'(addr) < RAM_WORDS) begin
          sel = (op == OP_MASK) ? mask : NIBBLE_W'(1) << idx;
          nib = shadow_nib[int'(addr)];
          nib = on ? (nib | sel) : (nib & ~sel);
          shadow_nib[int'(addr)] = nib;
          frames_due.push_back(nibble_write_frame(addr, nib, 1'b1));
        end
      end
      OP_RAW: frames_due.push_back(nibble_write_frame(addr, raw, 1'b1));
      OP_CMD: begin
        f.bits = {1'b0, CMD_HDR, code, 1'b0};
        f.len  = FRAME_LEN_CMD;
        f.last = 1'b1;
        frames_due.push_back(f);
      end
      OP_CLEAR, OP_FILL: begin
        nib = (op == OP_FILL) ? NIBBLE_ALL : '0;
        for (int k = 0; k < RAM_WORDS; k++) begin
          shadow_nib[k] = nib;
          frames_due.push_back(nibble_write_frame(ADDR_W'(k), nib, k == RAM_WORDS - 1));
        end
      end
      default: ;  // spare op codes: no frame, no state change
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcd_frame_t want;
    if (!rst_ni) begin
      for (int k = 0; k < RAM_WORDS; k++) shadow_nib[k] = '0;
      frames_due.delete();
      mismatches_o = 0;
    end else begin
      // drain before fill: a request never yields a frame on its own accept edge
      if (frame_mon.valid && frame_mon.ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: frame transfer with none expected: got bits=%h len=%0d last=%0b",
                   $time, frame_mon.frame_bits, frame_mon.frame_length, frame_mon.last);
          mismatches_o++;
        end else begin
          want = frames_due.pop_front();
          if (frame_mon.frame_bits !== want.bits || frame_mon.frame_length !== want.len ||
              frame_mon.last !== want.last) begin
            $display({"%0t: frame mismatch: expected bits=%h len=%0d last=%0b,",
                      " got bits=%h len=%0d last=%0b"},
                     $time, want.bits, want.len, want.last,
                     frame_mon.frame_bits, frame_mon.frame_length, frame_mon.last);
            mismatches_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        apply_request(req_mon.op, req_mon.address, req_mon.bit_mask, req_mon.bit_index,
                      req_mon.turn_on, req_mon.raw_nibble, req_mon.command_code);
      end
    end
    frames_pending_o = frames_due.size();
  end

endmodule

// ----- tb/tb_segment_lcd_shadow_writer.sv -----
`timescale 1ns / 100ps

module tb_segment_lcd_shadow_writer;
  import slw_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatches;
  int   frames_pending;
  int   cycles = 0;
  bit   quiet = 1'b0;      // no idling on either side
  bit   hold_req = 1'b0;   // ask the frame side for one long hold-off
  int   calm_left = 0;

  always #10 clk_i = ~clk_i;

  slw_in_if  req_ch ();
  slw_out_if frame_ch ();

  segment_lcd_shadow_writer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (frame_ch)
  );

  slw_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_ch),
    .frame_mon        (frame_ch),
    .mismatches_o     (mismatches),
    .frames_pending_o (frames_pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_lcd_shadow_writer regression: fail");
      $finish;
    end
  end

  // frame side: random stall bursts, calm stretches, one long hold-off on request
  initial begin
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        frame_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        frame_ch.ready <= 1'b1;
      end else if (quiet || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        frame_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        calm_left = $urandom_range(20, 80);
        frame_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        frame_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        frame_ch.ready <= 1'b1;
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                       input logic [NIBBLE_W-1:0] mask, input logic [BIDX_W-1:0] idx,
                       input logic on, input logic [NIBBLE_W-1:0] raw,
                       input logic [CODE_W-1:0] code);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_ch.op           <= op;
    req_ch.address      <= addr;
    req_ch.bit_mask     <= mask;
    req_ch.bit_index    <= idx;
    req_ch.turn_on      <= on;
    req_ch.raw_nibble   <= raw;
    req_ch.command_code <= code;
    req_ch.valid        <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // returns 1 when the request produces at least one frame
  task automatic offer_random(output bit makes_frames);
    int                  pick;
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   addr;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_MASK;
    else if (pick < 55) op = OP_BIT;
    else if (pick < 70) op = OP_RAW;
    else if (pick < 85) op = OP_CMD;
    else if (pick < 90) op = OP_CLEAR;
    else if (pick < 95) op = OP_FILL;
    else                op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    if ($urandom_range(0, 9) < 8) addr = ADDR_W'($urandom_range(0, RAM_WORDS - 1));
    else                          addr = ADDR_W'($urandom_range(0, 63));
    makes_frames = (op == OP_RAW || op == OP_CMD || op == OP_CLEAR || op == OP_FILL ||
                    ((op == OP_MASK || op == OP_BIT) && int'(addr) < RAM_WORDS));
    offer(op, addr, NIBBLE_W'($urandom_range(0, 15)), BIDX_W'($urandom_range(0, 3)),
          1'($urandom_range(0, 1)), NIBBLE_W'($urandom_range(0, 15)),
          CODE_W'($urandom_range(0, 255)));
  endtask

  // let the checker log the last accepted request before waiting on the pending count
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (frames_pending == 0);
    @(posedge clk_i);
  endtask

  initial begin
    int counted;
    bit hit;
    rst_ni = 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.op           <= OP_MASK;
    req_ch.address      <= '0;
    req_ch.bit_mask     <= '0;
    req_ch.bit_index    <= '0;
    req_ch.turn_on      <= 1'b0;
    req_ch.raw_nibble   <= '0;
    req_ch.command_code <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every op, out-of-range updates, spare ops
    offer(OP_MASK, 6'd0, 4'hF, 2'd0, 1'b1, 4'h0, 8'h00);
    offer(OP_MASK, LAST_ADDR, 4'h5, 2'd0, 1'b1, 4'h0, 8'h00);
    offer(OP_MASK, LAST_ADDR, 4'h1, 2'd0, 1'b0, 4'h0, 8'h00);
    offer(OP_BIT, 6'd1, 4'h0, 2'd0, 1'b1, 4'h0, 8'h00);
    offer(OP_BIT, 6'd1, 4'h0, 2'd3, 1'b1, 4'h0, 8'h00);
    offer(OP_BIT, 6'd1, 4'h0, 2'd1, 1'b1, 4'h0, 8'h00);
    offer(OP_BIT, 6'd1, 4'h0, 2'd2, 1'b1, 4'h0, 8'h00);
    offer(OP_BIT, 6'd1, 4'h0, 2'd0, 1'b0, 4'h0, 8'h00);
    offer(OP_MASK, ADDR_W'(RAM_WORDS), 4'hF, 2'd0, 1'b1, 4'h0, 8'h00);
    offer(OP_MASK, 6'd63, 4'hF, 2'd3, 1'b1, 4'hF, 8'hFF);
    offer(OP_BIT, 6'd63, 4'hF, 2'd3, 1'b1, 4'hF, 8'hFF);
    offer(OP_RAW, 6'd63, 4'h0, 2'd0, 1'b0, 4'hA, 8'h00);
    offer(OP_RAW, 6'd0, 4'h0, 2'd0, 1'b0, 4'h0, 8'h00);
    offer(OP_RAW, 6'd21, 4'h0, 2'd0, 1'b0, 4'hF, 8'h00);
    offer(OP_CMD, 6'd0, 4'h0, 2'd0, 1'b0, 4'h0, 8'h00);
    offer(OP_CMD, 6'd63, 4'hF, 2'd3, 1'b1, 4'hF, 8'hFF);
    offer(OP_CMD, 6'd0, 4'h0, 2'd0, 1'b0, 4'h0, 8'h80);
    offer(OP_CMD, 6'd0, 4'h0, 2'd0, 1'b0, 4'h0, 8'h01);
    offer(OP_SPARE_LO, 6'd3, 4'hF, 2'd1, 1'b1, 4'h5, 8'h55);
    offer(OP_SPARE_HI, 6'd4, 4'hF, 2'd2, 1'b1, 4'hA, 8'hAA);
    offer(OP_FILL, 6'd0, 4'h0, 2'd0, 1'b0, 4'h0, 8'h00);
    offer(OP_MASK, 6'd5, 4'h6, 2'd0, 1'b0, 4'h0, 8'h00);
    offer(OP_CLEAR, 6'd0, 4'h0, 2'd0, 1'b0, 4'h0, 8'h00);
    offer(OP_BIT, LAST_ADDR, 4'h0, 2'd3, 1'b1, 4'h0, 8'h00);
    drain();

    counted = 0;
    while (counted < 70) begin
      if (counted == 20) begin
        // frame side holds off while requests keep coming, so the queue fills up
        hold_req = 1'b1;
        quiet = 1'b1;
        repeat (8) begin
          offer(OP_RAW, ADDR_W'($urandom_range(0, 63)), 4'h0, 2'd0, 1'b0,
                NIBBLE_W'($urandom_range(0, 15)), 8'h00);
          counted++;
        end
        quiet = 1'b0;
      end
      if (counted == 45) drain();
      if (counted >= 55) quiet = 1'b1;
      offer_random(hit);
      if (hit) counted++;
    end
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && frames_pending == 0)
      $display("segment_lcd_shadow_writer regression: pass");
    else $display("segment_lcd_shadow_writer regression: fail");
    $finish;
  end

endmodule
